// ===== rtl/core/point_in_triangle_test_assert.svh =====
// ----------------------------------------------------------------------------
// Point-in-triangle test assertion macros
// Concurrent assertion wrappers shared by the point-in-triangle test RTL.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TRIANGLE_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_TEST_ASSERT_SVH
`ifndef SYNTH
`define PIT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PIT_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);
`else
`define PIT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define PIT_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg)
`endif
`endif

// ===== rtl/core/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-triangle test package
// Widths, payload types and stage bundles shared by the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

    localparam int PIT_COORD_W = 16;
    localparam int PIT_DIFF_W  = PIT_COORD_W + 1;
    localparam int PIT_SQ_W    = 2 * PIT_DIFF_W;
    localparam int PIT_DOT_W   = 2 * PIT_COORD_W + 3;
    localparam int PIT_LO_W    = (PIT_DOT_W + 1) / 2;
    localparam int PIT_HI_W    = PIT_DOT_W - PIT_LO_W;
    localparam int PIT_PPH_W   = PIT_DOT_W + PIT_HI_W;
    localparam int PIT_PPL_W   = PIT_DOT_W + PIT_LO_W + 1;
    localparam int PIT_NUM_W   = 4 * PIT_COORD_W + 8;
    localparam int PIT_LATENCY = 7;

    typedef struct packed {
        logic signed [PIT_COORD_W-1:0] vertex_a_x;
        logic signed [PIT_COORD_W-1:0] vertex_a_y;
        logic signed [PIT_COORD_W-1:0] vertex_a_z;
        logic signed [PIT_COORD_W-1:0] vertex_b_x;
        logic signed [PIT_COORD_W-1:0] vertex_b_y;
        logic signed [PIT_COORD_W-1:0] vertex_b_z;
        logic signed [PIT_COORD_W-1:0] vertex_c_x;
        logic signed [PIT_COORD_W-1:0] vertex_c_y;
        logic signed [PIT_COORD_W-1:0] vertex_c_z;
        logic signed [PIT_COORD_W-1:0] point_x;
        logic signed [PIT_COORD_W-1:0] point_y;
        logic signed [PIT_COORD_W-1:0] point_z;
    } t_pit_req;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_pit_res;

    typedef logic signed [PIT_DIFF_W-1:0] t_pit_diff;
    typedef logic signed [PIT_SQ_W-1:0]   t_pit_sq;
    typedef logic signed [PIT_DOT_W-1:0]  t_pit_dot;
    typedef logic signed [PIT_NUM_W-1:0]  t_pit_num;

    typedef struct packed {
        t_pit_dot d00;
        t_pit_dot d11;
        t_pit_dot d01;
        t_pit_dot d02;
        t_pit_dot d12;
    } t_pit_dots;

    typedef struct packed {
        t_pit_num g;
        t_pit_num nu;
        t_pit_num nv;
    } t_pit_nums;

endpackage

`default_nettype wire

// ===== rtl/core/pit_dot.sv =====
// ----------------------------------------------------------------------------
// Point-in-triangle dot product stages
// Edge vectors, per-axis products and the five dot products (three stages).
// ----------------------------------------------------------------------------
`default_nettype none

module pit_dot (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_floor_mode,
    input  wire pit_pkg::t_pit_req i_req,
    output logic                   o_valid,
    output pit_pkg::t_pit_dots     o_dots
);
    import pit_pkg::*;

    logic      r_v1, r_v2, r_v3;
    t_pit_diff n_e0 [3];
    t_pit_diff n_e1 [3];
    t_pit_diff n_e2 [3];
    t_pit_diff r_e0 [3];
    t_pit_diff r_e1 [3];
    t_pit_diff r_e2 [3];
    t_pit_sq   n_s00 [3];
    t_pit_sq   n_s11 [3];
    t_pit_sq   n_s01 [3];
    t_pit_sq   n_s02 [3];
    t_pit_sq   n_s12 [3];
    t_pit_sq   r_s00 [3];
    t_pit_sq   r_s11 [3];
    t_pit_sq   r_s01 [3];
    t_pit_sq   r_s02 [3];
    t_pit_sq   r_s12 [3];
    t_pit_dots n_dots;
    t_pit_dots r_dots;

    always_comb begin
        n_e0[0] = t_pit_diff'(i_req.vertex_b_x) - t_pit_diff'(i_req.vertex_a_x);
        n_e0[1] = t_pit_diff'(i_req.vertex_b_y) - t_pit_diff'(i_req.vertex_a_y);
        n_e0[2] = t_pit_diff'(i_req.vertex_b_z) - t_pit_diff'(i_req.vertex_a_z);
        n_e1[0] = t_pit_diff'(i_req.vertex_c_x) - t_pit_diff'(i_req.vertex_a_x);
        n_e1[1] = t_pit_diff'(i_req.vertex_c_y) - t_pit_diff'(i_req.vertex_a_y);
        n_e1[2] = t_pit_diff'(i_req.vertex_c_z) - t_pit_diff'(i_req.vertex_a_z);
        n_e2[0] = t_pit_diff'(i_req.point_x) - t_pit_diff'(i_req.vertex_a_x);
        n_e2[1] = t_pit_diff'(i_req.point_y) - t_pit_diff'(i_req.vertex_a_y);
        n_e2[2] = t_pit_diff'(i_req.point_z) - t_pit_diff'(i_req.vertex_a_z);
        if (i_floor_mode) begin
            n_e0[1] = '0;
            n_e1[1] = '0;
            n_e2[1] = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s00[i] = t_pit_sq'(r_e0[i]) * t_pit_sq'(r_e0[i]);
            n_s11[i] = t_pit_sq'(r_e1[i]) * t_pit_sq'(r_e1[i]);
            n_s01[i] = t_pit_sq'(r_e0[i]) * t_pit_sq'(r_e1[i]);
            n_s02[i] = t_pit_sq'(r_e0[i]) * t_pit_sq'(r_e2[i]);
            n_s12[i] = t_pit_sq'(r_e1[i]) * t_pit_sq'(r_e2[i]);
        end
    end

    always_comb begin
        n_dots.d00 = t_pit_dot'(r_s00[0]) + t_pit_dot'(r_s00[1]) + t_pit_dot'(r_s00[2]);
        n_dots.d11 = t_pit_dot'(r_s11[0]) + t_pit_dot'(r_s11[1]) + t_pit_dot'(r_s11[2]);
        n_dots.d01 = t_pit_dot'(r_s01[0]) + t_pit_dot'(r_s01[1]) + t_pit_dot'(r_s01[2]);
        n_dots.d02 = t_pit_dot'(r_s02[0]) + t_pit_dot'(r_s02[1]) + t_pit_dot'(r_s02[2]);
        n_dots.d12 = t_pit_dot'(r_s12[0]) + t_pit_dot'(r_s12[1]) + t_pit_dot'(r_s12[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0   <= n_e0;
        r_e1   <= n_e1;
        r_e2   <= n_e2;
        r_s00  <= n_s00;
        r_s11  <= n_s11;
        r_s01  <= n_s01;
        r_s02  <= n_s02;
        r_s12  <= n_s12;
        r_dots <= n_dots;
    end

    assign o_valid = r_v3;
    assign o_dots  = r_dots;

endmodule

`default_nettype wire

// ===== rtl/core/pit_gram.sv =====
// ----------------------------------------------------------------------------
// Point-in-triangle Gram stages
// Split wide products of dot products, then the determinant and numerators.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_triangle_test_assert.svh"

module pit_gram (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire pit_pkg::t_pit_dots i_dots,
    output logic                    o_valid,
    output pit_pkg::t_pit_nums      o_nums
);
    import pit_pkg::*;

    localparam int PRODS = 6;

    logic                        r_v4, r_v5, r_v6;
    t_pit_dot                    pa [PRODS];
    t_pit_dot                    pb [PRODS];
    logic signed [PIT_HI_W-1:0]  bh [PRODS];
    logic signed [PIT_LO_W:0]    bl [PRODS];
    logic signed [PIT_PPH_W-1:0] n_pph [PRODS];
    logic signed [PIT_PPL_W-1:0] n_ppl [PRODS];
    logic signed [PIT_PPH_W-1:0] r_pph [PRODS];
    logic signed [PIT_PPL_W-1:0] r_ppl [PRODS];
    t_pit_num                    n_prod [PRODS];
    t_pit_num                    r_prod [PRODS];
    t_pit_nums                   n_nums;
    t_pit_nums                   r_nums;

    always_comb begin
        pa[0] = i_dots.d00;
        pb[0] = i_dots.d11;
        pa[1] = i_dots.d01;
        pb[1] = i_dots.d01;
        pa[2] = i_dots.d11;
        pb[2] = i_dots.d02;
        pa[3] = i_dots.d01;
        pb[3] = i_dots.d12;
        pa[4] = i_dots.d00;
        pb[4] = i_dots.d12;
        pa[5] = i_dots.d01;
        pb[5] = i_dots.d02;
        for (int k = 0; k < PRODS; k++) begin
            bh[k]    = $signed(pb[k][PIT_DOT_W-1:PIT_LO_W]);
            bl[k]    = $signed({1'b0, pb[k][PIT_LO_W-1:0]});
            n_pph[k] = PIT_PPH_W'(pa[k]) * PIT_PPH_W'(bh[k]);
            n_ppl[k] = PIT_PPL_W'(pa[k]) * PIT_PPL_W'(bl[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < PRODS; k++) begin
            n_prod[k] = (t_pit_num'(r_pph[k]) <<< PIT_LO_W) + t_pit_num'(r_ppl[k]);
        end
    end

    always_comb begin
        n_nums.g  = r_prod[0] - r_prod[1];
        n_nums.nu = r_prod[2] - r_prod[3];
        n_nums.nv = r_prod[4] - r_prod[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pph  <= n_pph;
        r_ppl  <= n_ppl;
        r_prod <= n_prod;
        r_nums <= n_nums;
    end

    assign o_valid = r_v6;
    assign o_nums  = r_nums;

    `PIT_ASSERT_IMPLIES(a_gram_nonneg, i_clk, i_rst_n, r_v6, !r_nums.g[PIT_NUM_W-1], "Gram determinant is negative.")

endmodule

`default_nettype wire

// ===== rtl/core/pit_decide.sv =====
// ----------------------------------------------------------------------------
// Point-in-triangle decision stage
// Sign and slack tests on the numerators, registered result and strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pit_decide (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire pit_pkg::t_pit_nums i_nums,
    output logic                    o_valid,
    output pit_pkg::t_pit_res       o_res
);
    import pit_pkg::*;

    logic     r_valid;
    t_pit_num slack;
    logic     degen;
    t_pit_res n_res;
    t_pit_res r_res;

    always_comb begin
        slack = i_nums.g - i_nums.nu - i_nums.nv;
        degen = (i_nums.g == '0);
        n_res.degenerate = degen;
        n_res.inside_res = !degen && !i_nums.nu[PIT_NUM_W-1] && !i_nums.nv[PIT_NUM_W-1]
                           && !slack[PIT_NUM_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== rtl/core/point_in_triangle_test.sv =====
// ----------------------------------------------------------------------------
// Point-in-triangle test
// Exact barycentric inside test of a point against a triangle in 3D or floor.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// It carries the three vertices and the test point as signed Q12.4 values.
// Busy is high during reset and until r_ready is set after it, and low
// otherwise, so a new request may be issued in every cycle.
// Each request yields one result on o_res, marked by o_res_valid for one
// cycle; results leave in request order. The receiver cannot stall the
// block, and none is needed.
// The latency comes from seven register stages: edge vectors, axis products,
// dot products, split partial products, wide products, numerators, and the
// final decision.
// The user writes the floor mode register via i_floor_mode_we only while no
// request is in flight (not enforced); it applies to later requests.
// Reset clears the floor mode and drops every request in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "point_in_triangle_test_assert.svh"

module point_in_triangle_test (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pit_pkg::t_pit_req i_req,
    input  wire logic              i_floor_mode_we,
    input  wire logic              i_floor_mode_wdata,
    output logic                   o_res_valid,
    output pit_pkg::t_pit_res      o_res
);
    import pit_pkg::*;

    logic      r_ready;
    logic      r_floor_mode;
    logic      accept;
    logic      dot_valid;
    t_pit_dots dots;
    logic      gram_valid;
    t_pit_nums nums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= 1'b0;
            r_floor_mode <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (i_floor_mode_we) begin
                r_floor_mode <= i_floor_mode_wdata;
            end
        end
    end

    assign busy   = !r_ready;
    assign accept = start && !busy;

    pit_dot u_dot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_floor_mode (r_floor_mode),
        .i_req        (i_req),
        .o_valid      (dot_valid),
        .o_dots       (dots)
    );

    pit_gram u_gram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dot_valid),
        .i_dots  (dots),
        .o_valid (gram_valid),
        .o_nums  (nums)
    );

    pit_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (gram_valid),
        .i_nums  (nums),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

    `PIT_ASSERT_DELAY(a_req_gives_res, i_clk, i_rst_n, accept, PIT_LATENCY, o_res_valid, "Request produced no result.")
    `PIT_ASSERT_IMPLIES(a_res_has_req, i_clk, i_rst_n, o_res_valid, $past(accept, PIT_LATENCY), "Result without a request.")
    `PIT_ASSERT_IMPLIES(a_degen_outside, i_clk, i_rst_n, o_res_valid && o_res.degenerate, !o_res.inside_res, "Degenerate triangle reported inside.")

endmodule

`default_nettype wire
